// ===== design/fra_pkg.sv =====
`timescale 1ns / 1ps
package fra_pkg;

  // Fixed widths of the item fields.
  localparam int IDX_W  = 17;
  localparam int VAL_W  = 16;
  localparam int DATA_W = 32;

  // Default number of tree positions.
  localparam int DEF_SIZE = 131072;

  // Depth of the operation queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } command_e;

endpackage

// ===== design/fra_queue.sv =====
`timescale 1ns / 1ps
module fra_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = fra_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = slots_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/fra_front.sv =====
`timescale 1ns / 1ps
module fra_front #(
  parameter int SIZE = fra_pkg::DEF_SIZE,
  parameter int KW   = $clog2(SIZE + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clearing_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [fra_pkg::IDX_W-1:0]    left_index_i,
  input  logic [fra_pkg::IDX_W-1:0]    right_index_i,
  input  logic signed [fra_pkg::VAL_W-1:0] add_value_i,
  input  logic [fra_pkg::IDX_W-1:0]    query_index_i,
  output logic                         push_o,
  output logic                         push_query_o,
  output logic [KW-1:0]                push_k_o,
  output logic [fra_pkg::DATA_W-1:0]   push_amount_o,
  input  logic                         full_i
);
  import fra_pkg::*;

  // Wide enough for right_index + 1 and for SIZE itself.
  localparam int PW = (KW > IDX_W + 1) ? KW : IDX_W + 1;

  logic              have_q;
  logic              phase_q;
  command_e          cmd_q;
  logic [IDX_W-1:0]  left_q, right_q, query_q;
  logic [DATA_W-1:0] amt_q;

  logic [PW-1:0]     size_w, pos, pos_inc;
  logic              in_range, last, step, accept;

  assign size_w     = PW'(SIZE);
  assign in_stall_o = have_q || clearing_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    pos           = '0;
    in_range      = 1'b1;
    push_amount_o = amt_q;
    if (cmd_q == CMD_QUERY) begin
      // Queries past the end read the last position.
      pos = (PW'(query_q) >= size_w) ? size_w - PW'(1) : PW'(query_q);
    end else if (!phase_q) begin
      pos      = PW'(left_q);
      in_range = (pos < size_w);
    end else begin
      pos           = PW'(right_q) + PW'(1);
      in_range      = (pos < size_w);
      push_amount_o = '0 - amt_q;
    end
  end

  assign pos_inc      = pos + PW'(1);
  assign push_k_o     = pos_inc[KW-1:0];
  assign push_query_o = (cmd_q == CMD_QUERY);
  assign last         = (cmd_q == CMD_QUERY) || phase_q;
  assign push_o       = have_q && in_range && !full_i;
  assign step         = have_q && (!in_range || !full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q  <= 1'b0;
      phase_q <= 1'b0;
    end else if (accept) begin
      have_q  <= 1'b1;
      phase_q <= 1'b0;
    end else if (step) begin
      if (last) begin
        have_q <= 1'b0;
      end else begin
        phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= command_e'(command_i);
      left_q  <= left_index_i;
      right_q <= right_index_i;
      query_q <= query_index_i;
      amt_q   <= DATA_W'(add_value_i);
    end
  end

endmodule

// ===== design/fra_engine.sv =====
`timescale 1ns / 1ps
module fra_engine #(
  parameter int SIZE = fra_pkg::DEF_SIZE,
  parameter int KW   = $clog2(SIZE + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  output logic                       clearing_o,
  input  logic                       op_valid_i,
  output logic                       op_pop_o,
  input  logic                       op_query_i,
  input  logic [KW-1:0]              op_k_i,
  input  logic [fra_pkg::DATA_W-1:0] op_amount_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [fra_pkg::DATA_W-1:0] point_value_o
);
  import fra_pkg::*;

  localparam int AW = $clog2(SIZE);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  logic [DATA_W-1:0] mem [SIZE];
  logic [DATA_W-1:0] rdata_q;

  logic [1:0]        state_q, state_d;
  logic [AW-1:0]     clr_q;
  logic [KW-1:0]     k_q, k_d;
  logic [DATA_W-1:0] amt_q, acc_q, out_q;
  logic              query_q, out_valid_q;

  logic [KW-1:0]     low_bit, dn_next, k_m1, op_m1, dn_m1;
  logic [KW:0]       up_next, up_m1;
  logic              up_done, dn_done, out_free, start, finish;
  logic [DATA_W-1:0] sum;

  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data;

  assign low_bit  = k_q & (~k_q + KW'(1));
  assign up_next  = {1'b0, k_q} + {1'b0, low_bit};
  assign dn_next  = k_q - low_bit;
  assign up_done  = (up_next > (KW + 1)'(SIZE));
  assign dn_done  = (dn_next == '0);
  assign k_m1     = k_q - KW'(1);
  assign op_m1    = op_k_i - KW'(1);
  assign dn_m1    = dn_next - KW'(1);
  assign up_m1    = up_next - (KW + 1)'(1);
  assign sum      = rdata_q + (query_q ? acc_q : amt_q);

  assign out_free = !out_valid_q || !out_stall_i;
  assign start    = (state_q == ST_IDLE) && op_valid_i && (!op_query_i || out_free);
  assign finish   = (state_q == ST_WALK) && (query_q ? dn_done : up_done);

  assign op_pop_o      = start;
  assign clearing_o    = (state_q == ST_CLEAR);
  assign out_valid_o   = out_valid_q;
  assign point_value_o = out_q;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        if (clr_q == AW'(SIZE - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          rd_en   = 1'b1;
          rd_addr = op_m1[AW-1:0];
          k_d     = op_k_i;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!query_q) begin
          // Write back this node and fetch the next one up in the same cycle.
          wr_en   = 1'b1;
          wr_addr = k_m1[AW-1:0];
          wr_data = sum;
          if (!up_done) begin
            rd_en   = 1'b1;
            rd_addr = up_m1[AW-1:0];
            k_d     = up_next[KW-1:0];
          end
        end else if (!dn_done) begin
          rd_en   = 1'b1;
          rd_addr = dn_m1[AW-1:0];
          k_d     = dn_next;
        end
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (finish && query_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    if (start) begin
      query_q <= op_query_i;
      amt_q   <= op_amount_i;
      acc_q   <= '0;
    end else if (state_q == ST_WALK && query_q) begin
      acc_q <= sum;
    end
    if (finish && query_q) begin
      out_q <= sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

endmodule

// ===== design/fenwick_range_add_point_query.sv =====
`timescale 1ns / 1ps
// Each walk in the back takes a start step and then one tree node a cycle; a range add
// makes up to two walks and a query makes one.
// Reset: asynchronous and active low; afterwards a clearing pass writes zero to all SIZE
// entries, one a cycle, and in_stall_o stays high until that pass is done.
module fenwick_range_add_point_query #(
  parameter int SIZE = fra_pkg::DEF_SIZE
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [fra_pkg::IDX_W-1:0]         left_index_i,
  input  logic [fra_pkg::IDX_W-1:0]         right_index_i,
  input  logic signed [fra_pkg::VAL_W-1:0]  add_value_i,
  input  logic [fra_pkg::IDX_W-1:0]         query_index_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [fra_pkg::DATA_W-1:0] point_value_o
);
  import fra_pkg::*;

  // A tree node number runs from 1 to SIZE, so it needs one bit more than an address
  // when SIZE is a power of two.
  localparam int KW  = $clog2(SIZE + 1);
  localparam int OPW = 1 + KW + DATA_W;

  logic              clearing;
  logic              push, full;
  logic              push_query;
  logic [KW-1:0]     push_k;
  logic [DATA_W-1:0] push_amount;

  logic              op_valid, op_pop;
  logic [OPW-1:0]    op_data;
  logic [DATA_W-1:0] point_value;

  // The front takes one beat at a time and turns it into tree operations: a query
  // becomes one downward walk, and a range add becomes up to two upward walks, one at
  // left_index with the value and one just past right_index with its negation. A walk
  // that would start past the last position is dropped here and never reaches the queue.
  fra_front #(
    .SIZE (SIZE),
    .KW   (KW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clearing_i    (clearing),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .left_index_i  (left_index_i),
    .right_index_i (right_index_i),
    .add_value_i   (add_value_i),
    .query_index_i (query_index_i),
    .push_o        (push),
    .push_query_o  (push_query),
    .push_k_o      (push_k),
    .push_amount_o (push_amount),
    .full_i        (full)
  );

  // The queue lets the front keep taking beats while the back is busy walking the tree
  // or is waiting for the output register to drain.
  fra_queue #(
    .WIDTH (OPW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_query, push_k, push_amount}),
    .full_o      (full),
    .pop_i       (op_pop),
    .valid_o     (op_valid),
    .pop_data_o  (op_data)
  );

  // The back owns the tree memory. An update walk does one read-modify-write a cycle,
  // reading the next node while writing the current one; a query walk accumulates one
  // node a cycle. Query results land in an output register.
  fra_engine #(
    .SIZE (SIZE),
    .KW   (KW)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clearing_o    (clearing),
    .op_valid_i    (op_valid),
    .op_pop_o      (op_pop),
    .op_query_i    (op_data[OPW-1]),
    .op_k_i        (op_data[DATA_W +: KW]),
    .op_amount_i   (op_data[DATA_W-1:0]),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .point_value_o (point_value)
  );

  assign point_value_o = point_value;

endmodule
